>>> sv/smbr_pkg.sv
// shared types and constants for the splitmix64 bounded generator
`timescale 1ns / 1ps
package smbr_pkg;
  localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;
  localparam int unsigned MIX_SH_A = 30;
  localparam int unsigned MIX_SH_B = 27;
  localparam int unsigned MIX_SH_C = 31;

  localparam logic CMD_RAW     = 1'b0;
  localparam logic CMD_BOUNDED = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_LIMIT_WAIT,
    ST_DRAW,
    ST_MUL_A,
    ST_MUL_A_WAIT,
    ST_MUL_B,
    ST_MUL_B_WAIT,
    ST_CHECK,
    ST_MOD_WAIT,
    ST_OUT
  } state_t;

  // datapath commands, one pulse each
  typedef struct packed {
    logic load;
    logic advance;
    logic mul_a;
    logic mul_b;
    logic start_limit;
    logic start_mod;
    logic out_zero;
    logic out_raw;
    logic out_mod;
  } ctrl_t;

  typedef struct packed {
    logic bounded;
    logic bound_zero;
    logic div_done;
    logic mul_done;
    logic draw_ok;
  } stat_t;
endpackage

>>> sv/smbr_divider.sv
// radix-2 restoring 64-bit remainder unit, one bit per cycle
`timescale 1ns / 1ps
module smbr_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] remainder
);
  import smbr_pkg::*;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] div_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;
  logic [64:0] shifted;

  always_comb begin
    shifted  = {rem_r[63:0], quo_r[63]};
    trial    = shifted - {1'b0, div_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[62:0], 1'b0};
      rem_nxt = trial[64] ? shifted : trial;
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) div_r <= divisor;
  end

  assign done      = done_r;
  assign remainder = rem_r[63:0];
endmodule

>>> sv/smbr_datapath.sv
// generator state, mixing rounds, remainder unit and output register
`timescale 1ns / 1ps
module smbr_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [63:0]     cfg_wdata,
  input  logic            in_cmd,
  input  logic [63:0]     in_bound,
  input  smbr_pkg::ctrl_t ctrl,
  output smbr_pkg::stat_t stat,
  output logic [63:0]     out_value
);
  import smbr_pkg::*;
  logic [63:0] state_r;
  logic [63:0] z_r;
  logic [63:0] bound_r;
  logic        cmd_r;
  logic [63:0] limit_r;
  logic [63:0] value_r;
  logic [63:0] z_final;
  logic        div_start;
  logic [63:0] div_dividend;
  logic        div_done;
  logic [63:0] div_rem;
  logic [63:0] mx_r;
  logic [63:0] mk_r;
  logic [63:0] acc_r;
  logic [2:0]  mul_ph_r;
  logic [31:0] mop_a;
  logic [31:0] mop_b;
  logic [63:0] mprod;

  assign z_final = z_r ^ (z_r >> MIX_SH_C);
  assign div_start = ctrl.start_limit | ctrl.start_mod;
  assign div_dividend = ctrl.start_limit ? (64'd0 - bound_r) : z_final;

  // low 64 bits of the product from three 32-bit partial products
  assign mop_a = mul_ph_r[1] ? mx_r[63:32] : mx_r[31:0];
  assign mop_b = mul_ph_r[2] ? mk_r[63:32] : mk_r[31:0];
  assign mprod = 64'(mop_a) * 64'(mop_b);

  smbr_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (bound_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_ph_r <= '0;
    end else begin
      mul_ph_r <= {mul_ph_r[1:0], ctrl.mul_a | ctrl.mul_b};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (cfg_we) begin
      state_r <= cfg_wdata;
    end else if (ctrl.advance) begin
      state_r <= state_r + GOLDEN_INC;
    end
    if (ctrl.load) begin
      bound_r <= in_bound;
      cmd_r   <= in_cmd;
    end
    if (ctrl.mul_a) begin
      mx_r <= z_r ^ (z_r >> MIX_SH_A);
      mk_r <= MIX_MUL_A;
    end
    if (ctrl.mul_b) begin
      mx_r <= z_r ^ (z_r >> MIX_SH_B);
      mk_r <= MIX_MUL_B;
    end
    if (mul_ph_r[0]) acc_r <= mprod;
    if (mul_ph_r[1]) acc_r[63:32] <= acc_r[63:32] + mprod[31:0];
    if (ctrl.advance) z_r <= state_r + GOLDEN_INC;
    if (mul_ph_r[2]) z_r <= {acc_r[63:32] + mprod[31:0], acc_r[31:0]};
    if (div_done && !ctrl.out_mod) limit_r <= div_rem;
    if (ctrl.out_zero) value_r <= '0;
    if (ctrl.out_raw) value_r <= z_final;
    if (ctrl.out_mod) value_r <= div_rem;
  end

  assign stat.bounded    = cmd_r == CMD_BOUNDED;
  assign stat.bound_zero = bound_r == 64'd0;
  assign stat.div_done   = div_done;
  assign stat.mul_done   = mul_ph_r[2];
  assign stat.draw_ok    = z_final >= limit_r;
  assign out_value       = value_r;
endmodule

>>> sv/smbr_ctrl.sv
// sequencing state machine and stream handshakes
`timescale 1ns / 1ps
module smbr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  smbr_pkg::stat_t stat,
  output smbr_pkg::ctrl_t ctrl
);
  import smbr_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    ctrl       = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctrl.load = 1'b1;
          state_nxt = ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        if (!stat.bounded) begin
          state_nxt = ST_DRAW;
        end else if (stat.bound_zero) begin
          ctrl.out_zero = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          ctrl.start_limit = 1'b1;
          state_nxt = ST_LIMIT_WAIT;
        end
      end
      ST_LIMIT_WAIT: if (stat.div_done) state_nxt = ST_DRAW;
      ST_DRAW: begin
        ctrl.advance = 1'b1;
        state_nxt = ST_MUL_A;
      end
      ST_MUL_A: begin
        ctrl.mul_a = 1'b1;
        state_nxt = ST_MUL_A_WAIT;
      end
      ST_MUL_A_WAIT: if (stat.mul_done) state_nxt = ST_MUL_B;
      ST_MUL_B: begin
        ctrl.mul_b = 1'b1;
        state_nxt = ST_MUL_B_WAIT;
      end
      ST_MUL_B_WAIT: if (stat.mul_done) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!stat.bounded) begin
          ctrl.out_raw = 1'b1;
          state_nxt = ST_OUT;
        end else if (stat.draw_ok) begin
          ctrl.start_mod = 1'b1;
          state_nxt = ST_MOD_WAIT;
        end else begin
          state_nxt = ST_DRAW;
        end
      end
      ST_MOD_WAIT: begin
        if (stat.div_done) begin
          ctrl.out_mod = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_mod_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start_mod |-> stat.bounded && !stat.bound_zero) else $error("bad mod start");
endmodule

>>> sv/splitmix64_bounded_rng.sv
// top level of the splitmix64 generator with bounded draws
// One item at a time; the input is ready again in the cycle after the result is
// taken. Each draw runs two 64-bit multiplies, each built from three 32-bit
// partial products. A bounded draw with a nonzero bound makes two passes of
// the shared bit-serial remainder unit, and draws again for each rejected
// value. A zero bound returns 0 without a remainder pass. Writing the seed
// also loads the running state; write it only while no item is in flight.
`timescale 1ns / 1ps
module splitmix64_bounded_rng (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // upper_bound
  input  logic         in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata   // value
);
  import smbr_pkg::*;
  ctrl_t ctrl;
  stat_t stat;

  smbr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  smbr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_cmd    (in_tuser),
    .in_bound  (in_tdata),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_value (out_tdata)
  );
endmodule

>>> tb/testbench.sv
// testbench for the splitmix64 bounded generator: random and directed draws checked against a local model
`timescale 1ns / 1ps
module testbench;
  import smbr_pkg::*;

  typedef struct packed {
    logic        cmd;
    logic [63:0] bound;
  } draw_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  draw_req_t   pending_reqs[$];
  logic [63:0] expected_values[$];
  logic [63:0] rng_state;
  int          error_count = 0;
  int          draws_checked = 0;
  int          bounded_sent = 0;
  int          in_idle = 0;
  int          out_idle = 0;
  bit          calm = 1'b0;

  splitmix64_bounded_rng dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] mix_next();
    logic [63:0] z;
    rng_state = rng_state + GOLDEN_INC;
    z = rng_state;
    z = (z ^ (z >> MIX_SH_A)) * MIX_MUL_A;
    z = (z ^ (z >> MIX_SH_B)) * MIX_MUL_B;
    return z ^ (z >> MIX_SH_C);
  endfunction

  function automatic logic [63:0] predict_draw(draw_req_t r);
    logic [63:0] thresh;
    logic [63:0] z;
    if (r.cmd == CMD_RAW) return mix_next();
    if (r.bound == 64'd0) return 64'd0;
    thresh = (64'd0 - r.bound) % r.bound;
    z = mix_next();
    while (z < thresh) z = mix_next();
    return z % r.bound;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (in_idle > 0) begin
          in_idle--;
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_idle = $urandom_range(1, 17);
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          draw_req_t r;
          r = pending_reqs.pop_front();
          expected_values.push_back(predict_draw(r));
          if (r.cmd == CMD_BOUNDED) bounded_sent++;
          in_tvalid <= 1'b1;
          in_tuser <= r.cmd;
          in_tdata <= r.bound;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      if (out_idle > 0) begin
        out_idle--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_idle = $urandom_range(1, 17);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_values.size() == 0) begin
        report_mismatch($sformatf("unexpected value %h", out_tdata));
      end else begin
        logic [63:0] exp_v;
        exp_v = expected_values.pop_front();
        if (out_tdata !== exp_v)
          report_mismatch($sformatf("value got %h exp %h", out_tdata, exp_v));
        draws_checked++;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_bound();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return 64'(1) << $urandom_range(0, 63);
      2: return 64'($urandom_range(1, 20));
      3: return ~64'd0 - 64'($urandom_range(0, 5));
      4: return (64'd1 << 63) + 64'($urandom_range(0, 1000));
      5: return {1'b1, 63'(rand64())};
      default: return rand64() >> $urandom_range(0, 63);
    endcase
  endfunction

  task automatic push_req(logic cmd, logic [63:0] bound);
    draw_req_t r;
    r.cmd = cmd;
    r.bound = bound;
    pending_reqs.push_back(r);
  endtask

  task automatic drain_and_seed(logic [63:0] seed);
    while (pending_reqs.size() > 0 || in_tvalid || expected_values.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= seed;
    rng_state = seed;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rng_state = 64'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: reset seed, extremes and special cases
    push_req(CMD_RAW, 64'd0);
    push_req(CMD_RAW, ~64'd0);
    push_req(CMD_BOUNDED, 64'd0);
    push_req(CMD_BOUNDED, 64'd1);
    push_req(CMD_BOUNDED, 64'd2);
    push_req(CMD_BOUNDED, 64'd3);
    push_req(CMD_BOUNDED, ~64'd0);
    push_req(CMD_BOUNDED, 64'h8000_0000_0000_0000);
    push_req(CMD_BOUNDED, 64'h8000_0000_0000_0001);
    push_req(CMD_BOUNDED, 64'hC000_0000_0000_0000);
    push_req(CMD_BOUNDED, 64'hAAAA_AAAA_AAAA_AAAA);
    push_req(CMD_BOUNDED, 64'h5555_5555_5555_5555);
    drain_and_seed(~64'd0);
    push_req(CMD_RAW, 64'h1234);
    push_req(CMD_BOUNDED, 64'hFFFF_FFFF_0000_0001);
    push_req(CMD_BOUNDED, 64'd0);
    push_req(CMD_RAW, 64'd0);
    drain_and_seed(64'd0 - GOLDEN_INC);
    push_req(CMD_RAW, 64'd0);
    push_req(CMD_BOUNDED, 64'd7);
    // random phases with varying seeds
    for (int ph = 0; ph < 5; ph++) begin
      drain_and_seed(rand64());
      if (ph == 4) calm = 1'b1;
      for (int i = 0; i < 300; i++)
        push_req(1'($urandom()), rand_bound());
    end
    while (pending_reqs.size() > 0 || in_tvalid || expected_values.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    $display("checked %0d draws, %0d of them bounded, over 8 seed settings",
             draws_checked, bounded_sent);
    if (error_count == 0 && expected_values.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
